// ===== rtl/ghal_pkg.sv =====
// Shared types and constants of the generational handle allocator.
// No dependencies; the interfaces and the allocator modules import this package.
`default_nettype none

package ghal_pkg;

	// Sizing
	localparam int SLOT_COUNT = 1024;
	localparam int GEN_WIDTH  = 16;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;

	localparam logic [GEN_WIDTH-1:0] GEN_MAX = {GEN_WIDTH{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 3'd0,
		OP_RESERVE = 3'd1,
		OP_DESTROY = 3'd2,
		OP_RELEASE = 3'd3,
		OP_COMMIT  = 3'd4,
		OP_CHECK   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_STALE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		COND_FREE     = 2'd0,
		COND_RESERVED = 2'd1,
		COND_ALIVE    = 2'd2
	} cond_t;

	// One entry of the slot memory
	typedef struct packed {
		logic [GEN_WIDTH-1:0] gen;
		cond_t                cond;
	} slot_ent_t;

	localparam int SLOT_ENT_W = $bits(slot_ent_t);

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		slot_ent_t        data;
	} slot_wr_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} stack_wr_t;

endpackage

`default_nettype wire

// ===== rtl/ghal_req_if.sv =====
// Request channel: valid/ready handshake carrying one operation word.
// Depends on ghal_pkg for field widths.
`default_nettype none

interface ghal_req_if;
	import ghal_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [IDX_W-1:0]     handle_index;
	logic [GEN_WIDTH-1:0] handle_generation;

	modport source (output valid, output op, output handle_index,
		output handle_generation, input ready);
	modport sink (input valid, input op, input handle_index,
		input handle_generation, output ready);
endinterface

`default_nettype wire

// ===== rtl/ghal_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result word.
// Depends on ghal_pkg for field widths.
`default_nettype none

interface ghal_rsp_if;
	import ghal_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [IDX_W-1:0]     out_index;
	logic [GEN_WIDTH-1:0] out_generation;

	modport source (output valid, output status, output out_index,
		output out_generation, input ready);
	modport sink (input valid, input status, input out_index,
		input out_generation, output ready);
endinterface

`default_nettype wire

// ===== rtl/generational_handle_allocator.sv =====
// Generational handle allocator: slot memory, free-stack memory, sequencer.
// A taken request reads the slot memory; the execute state then decides, writes
// back and fills the result register. Allocate/reserve with a pop read the free
// stack first (stack read, then slot read). No new request is taken until the
// last one writes back; execute waits while an unread result is held. Reset
// clears state, counters and result valid only; memories are not cleared and need no pass.
`default_nettype none

module generational_handle_allocator (
	input wire logic clk,
	input wire logic arst_n,
	ghal_req_if.sink   req,
	ghal_rsp_if.source rsp
);
	import ghal_pkg::*;

	mem_rd_t          slot_rd, stack_rd;
	slot_wr_t         slot_wr;
	stack_wr_t        stack_wr;
	slot_ent_t        slot_rdata;
	logic [IDX_W-1:0] stack_rdata;

	ghal_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.slot_rd     (slot_rd),
		.slot_rdata  (slot_rdata),
		.slot_wr     (slot_wr),
		.stack_rd    (stack_rd),
		.stack_rdata (stack_rdata),
		.stack_wr    (stack_wr)
	);

	// Generation and condition of every slot
	ghal_ram #(
		.WIDTH (SLOT_ENT_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_wr.we),
		.waddr (slot_wr.addr),
		.wdata (slot_wr.data),
		.re    (slot_rd.re),
		.raddr (slot_rd.addr),
		.rdata (slot_rdata)
	);

	// LIFO of freed slot indices
	ghal_ram #(
		.WIDTH (IDX_W),
		.DEPTH (SLOT_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_wr.we),
		.waddr (stack_wr.addr),
		.wdata (stack_wr.data),
		.re    (stack_rd.re),
		.raddr (stack_rd.addr),
		.rdata (stack_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/ghal_ram.sv =====
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
`default_nettype none

module ghal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ghal_ctrl.sv =====
// Sequencer of the allocator: reads slot and free-stack memories, decides,
// writes back and fills the result register. Depends on ghal_pkg and the
// channel interfaces; it drives the two RAMs instantiated at the top level.
`default_nettype none

module ghal_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	ghal_req_if.sink                req,
	ghal_rsp_if.source              rsp,
	output      ghal_pkg::mem_rd_t  slot_rd,
	input  wire ghal_pkg::slot_ent_t slot_rdata,
	output      ghal_pkg::slot_wr_t slot_wr,
	output      ghal_pkg::mem_rd_t  stack_rd,
	input  wire logic [ghal_pkg::IDX_W-1:0] stack_rdata,
	output      ghal_pkg::stack_wr_t stack_wr
);
	import ghal_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t               state_q, state_nxt;
	op_t                  op_q;
	logic [GEN_WIDTH-1:0] hgen_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     opened_q, opened_nxt;
	logic [CNT_W-1:0]     depth_q, depth_nxt;

	logic                 rsp_valid_q;
	status_t              status_q, status_nxt;
	logic [IDX_W-1:0]     oidx_q, oidx_nxt;
	logic [GEN_WIDTH-1:0] ogen_q, ogen_nxt;

	logic accept, pop, fire, in_range, gen_ok;
	op_t  req_op;

	assign req_op   = op_t'(req.op);
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;
	// allocate/reserve with a non-empty free stack goes through the pop state
	assign pop      = ((req_op == OP_ALLOC) || (req_op == OP_RESERVE)) && (depth_q != '0);
	assign fire     = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	assign in_range = ({1'b0, idx_q} < opened_q);
	assign gen_ok   = (slot_rdata.gen == hgen_q);

	// Memory read requests and next state
	always_comb begin
		state_nxt     = state_q;
		slot_rd.re    = 1'b0;
		slot_rd.addr  = req.handle_index;
		stack_rd.re   = 1'b0;
		stack_rd.addr = depth_q[IDX_W-1:0] - IDX_W'(1);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (pop) begin
						stack_rd.re = 1'b1;
						state_nxt   = S_POP;
					end else begin
						slot_rd.re = 1'b1;
						state_nxt  = S_EXEC;
					end
				end
			end
			S_POP: begin
				slot_rd.re   = 1'b1;
				slot_rd.addr = stack_rdata;
				state_nxt    = S_EXEC;
			end
			S_EXEC: begin
				if (fire) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Decision and write-back
	always_comb begin
		opened_nxt    = opened_q;
		depth_nxt     = depth_q;
		status_nxt    = ST_STALE;
		oidx_nxt      = '0;
		ogen_nxt      = '0;
		slot_wr.we    = 1'b0;
		slot_wr.addr  = idx_q;
		slot_wr.data  = slot_rdata;
		stack_wr.we   = 1'b0;
		stack_wr.addr = depth_q[IDX_W-1:0];
		stack_wr.data = idx_q;
		unique case (op_q) inside
			OP_ALLOC, OP_RESERVE: begin
				slot_wr.data.cond = (op_q == OP_ALLOC) ? COND_ALIVE : COND_RESERVED;
				if (depth_q != '0) begin
					// reuse the popped slot with the next generation
					slot_wr.we       = 1'b1;
					slot_wr.data.gen = slot_rdata.gen + GEN_WIDTH'(1);
					depth_nxt        = depth_q - CNT_W'(1);
					status_nxt       = ST_OK;
					oidx_nxt         = idx_q;
					ogen_nxt         = slot_wr.data.gen;
				end else if (opened_q < CNT_W'(SLOT_COUNT)) begin
					// open a fresh slot at generation zero
					slot_wr.we       = 1'b1;
					slot_wr.addr     = opened_q[IDX_W-1:0];
					slot_wr.data.gen = '0;
					opened_nxt       = opened_q + CNT_W'(1);
					status_nxt       = ST_OK;
					oidx_nxt         = opened_q[IDX_W-1:0];
				end else begin
					status_nxt = ST_FULL;
				end
			end
			OP_DESTROY, OP_RELEASE: begin
				if (in_range && gen_ok && (slot_rdata.cond ==
						((op_q == OP_DESTROY) ? COND_ALIVE : COND_RESERVED))) begin
					slot_wr.we        = 1'b1;
					slot_wr.data.cond = COND_FREE;
					status_nxt        = ST_OK;
					// a slot at the top generation is retired
					if ((slot_rdata.gen != GEN_MAX) && (depth_q < CNT_W'(SLOT_COUNT))) begin
						stack_wr.we = 1'b1;
						depth_nxt   = depth_q + CNT_W'(1);
					end
				end
			end
			OP_COMMIT: begin
				if (in_range && gen_ok && (slot_rdata.cond == COND_RESERVED)) begin
					slot_wr.we        = 1'b1;
					slot_wr.data.cond = COND_ALIVE;
					status_nxt        = ST_OK;
				end
			end
			OP_CHECK: begin
				if (in_range && gen_ok && (slot_rdata.cond == COND_ALIVE)) begin
					status_nxt = ST_OK;
				end
			end
			default: status_nxt = ST_STALE;
		endcase
		if (!fire) begin
			slot_wr.we  = 1'b0;
			stack_wr.we = 1'b0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			opened_q    <= '0;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fire) begin
				opened_q    <= opened_nxt;
				depth_q     <= depth_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_op;
			hgen_q <= req.handle_generation;
			idx_q  <= req.handle_index;
		end else if (state_q == S_POP) begin
			idx_q <= stack_rdata;
		end
		if (fire) begin
			status_q <= status_nxt;
			oidx_q   <= oidx_nxt;
			ogen_q   <= ogen_nxt;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.out_index      = oidx_q;
	assign rsp.out_generation = ogen_q;

endmodule

`default_nettype wire
